// ===== rtl/core/bmsort_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsort_pkg
// shared types for the byte merge sorter: channel items, controller states,
// and the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package bmsort_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sorted_byte;
    logic       end_of_run;
    logic       overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic fill_en;   // accept one input item
    logic merge_en;  // move one element of the current merge pass
    logic emit_en;   // load one sorted byte into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sorted;     // run width already covers the whole string
    logic pass_end;   // current merge step writes the last element of a pass
    logic emit_last;  // current emit step moves the final byte
    logic out_free;   // output register can take a new item this cycle
  } status_t;

endpackage

// ===== rtl/core/bmsort_ram.sv =====
// ----------------------------------------------------------------------------
// bmsort_ram
// generic memory, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
module bmsort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// ===== rtl/core/bmsort_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmsort_ctrl
// sequencer for the byte merge sorter: fill, merge passes, emission
// ----------------------------------------------------------------------------
module bmsort_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  bmsort_pkg::status_t stat_i,
  output logic                in_stall_o,
  output bmsort_pkg::cmd_t    cmd_o
);

  bmsort_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmsort_pkg::ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bmsort_pkg::ST_FILL: begin
        in_stall_o    = 1'b0;
        cmd_o.fill_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = bmsort_pkg::ST_SETUP;
        end
      end
      // a quiet state so the first reads see settled memory
      bmsort_pkg::ST_SETUP: begin
        state_d = stat_i.sorted ? bmsort_pkg::ST_EMIT : bmsort_pkg::ST_MERGE;
      end
      bmsort_pkg::ST_MERGE: begin
        cmd_o.merge_en = 1'b1;
        if (stat_i.pass_end) begin
          state_d = bmsort_pkg::ST_SETUP;
        end
      end
      bmsort_pkg::ST_EMIT: begin
        cmd_o.emit_en = stat_i.out_free;
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = bmsort_pkg::ST_FILL;
        end
      end
      default: begin
        state_d = bmsort_pkg::ST_FILL;
      end
    endcase
  end

endmodule

// ===== rtl/core/bmsort_dp.sv =====
// ----------------------------------------------------------------------------
// bmsort_dp
// datapath: two ping-pong byte stores, merge pointers, output register
// ----------------------------------------------------------------------------
module bmsort_dp #(
  parameter int MAX_LEN = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmsort_pkg::in_item_t  in_item_i,
  input  bmsort_pkg::cmd_t      cmd_i,
  input  logic                  out_stall_i,
  output bmsort_pkg::status_t   stat_o,
  output logic                  out_valid_o,
  output bmsort_pkg::out_item_t out_item_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = CW + 2;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          dropped_q, dropped_d;
  logic          src_sel_q, src_sel_d;
  logic [CW-1:0] p_q, p_d, q_q, q_d, o_q, o_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW:0]   w_q, w_d;
  logic          out_valid_q, out_valid_d;
  bmsort_pkg::out_item_t out_q, out_d;

  logic [7:0]    m0_rd0, m0_rd1, m1_rd0, m1_rd1;
  logic [7:0]    head_a, head_b, merge_byte;
  logic          room, take_p, block_end, pass_end;
  logic [CW-1:0] n_next;
  logic          we0, we1;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  function automatic logic [CW-1:0] clip(input logic [SW-1:0] v, input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = (v > SW'(n)) ? n : v[CW-1:0];
    return r;
  endfunction

  assign room       = cnt_q < CW'(MAX_LEN);
  assign head_a     = src_sel_q ? m1_rd0 : m0_rd0;
  assign head_b     = src_sel_q ? m1_rd1 : m0_rd1;
  assign take_p     = (p_q < mid_q) && ((q_q >= hi_q) || (head_a <= head_b));
  assign merge_byte = take_p ? head_a : head_b;
  assign block_end  = ({1'b0, o_q} + (CW+1)'(1)) == {1'b0, hi_q};
  assign pass_end   = block_end && (hi_q == cnt_q);
  assign n_next     = room ? cnt_q + CW'(1) : cnt_q;

  assign stat_o.sorted    = {1'b0, cnt_q} <= w_q;
  assign stat_o.pass_end  = pass_end;
  assign stat_o.emit_last = ({1'b0, p_q} + (CW+1)'(1)) == {1'b0, cnt_q};
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    src_sel_d   = src_sel_q;
    p_d         = p_q;
    q_d         = q_q;
    o_d         = o_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    w_d         = w_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cmd_i.fill_en) begin
      if (room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
      // string closed: set up the first pass with runs of one byte
      if (in_item_i.last) begin
        w_d   = (CW+1)'(1);
        p_d   = '0;
        o_d   = '0;
        mid_d = clip(SW'(1), n_next);
        q_d   = mid_d;
        hi_d  = clip(SW'(2), n_next);
      end
    end

    if (cmd_i.merge_en) begin
      if (take_p) begin
        p_d = p_q + CW'(1);
      end else begin
        q_d = q_q + CW'(1);
      end
      o_d = o_q + CW'(1);
      if (pass_end) begin
        // runs double, source and destination swap
        w_d       = {w_q[CW-1:0], 1'b0};
        src_sel_d = !src_sel_q;
        o_d       = '0;
        p_d       = '0;
        mid_d     = clip(SW'(w_d), cnt_q);
        q_d       = mid_d;
        hi_d      = clip(SW'(w_d) << 1, cnt_q);
      end else if (block_end) begin
        p_d   = hi_q;
        mid_d = clip(SW'(hi_q) + SW'(w_q), cnt_q);
        q_d   = mid_d;
        hi_d  = clip(SW'(hi_q) + (SW'(w_q) << 1), cnt_q);
      end
    end

    if (cmd_i.emit_en) begin
      out_valid_d       = 1'b1;
      out_d.sorted_byte = head_a;
      out_d.end_of_run  = stat_o.emit_last;
      out_d.overflow    = dropped_q;
      p_d               = p_q + CW'(1);
      if (stat_o.emit_last) begin
        cnt_d     = '0;
        dropped_d = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      src_sel_q   <= 1'b0;
      p_q         <= '0;
      q_q         <= '0;
      o_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      dropped_q   <= dropped_d;
      src_sel_q   <= src_sel_d;
      p_q         <= p_d;
      q_q         <= q_d;
      o_q         <= o_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // fill writes the current source store, a merge writes the other one
  assign we0   = (cmd_i.fill_en && room && !src_sel_q) || (cmd_i.merge_en && src_sel_q);
  assign we1   = (cmd_i.fill_en && room && src_sel_q) || (cmd_i.merge_en && !src_sel_q);
  assign waddr = cmd_i.merge_en ? o_q[AW-1:0] : cnt_q[AW-1:0];
  assign wdata = cmd_i.merge_en ? merge_byte : in_item_i.ch;

  bmsort_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_ram0 (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (p_d[AW-1:0]),
    .raddr1_i (q_d[AW-1:0]),
    .rdata0_o (m0_rd0),
    .rdata1_o (m0_rd1)
  );

  bmsort_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_ram1 (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (p_d[AW-1:0]),
    .raddr1_i (q_d[AW-1:0]),
    .rdata0_o (m1_rd0),
    .rdata1_o (m1_rd1)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/byte_merge_sorter.sv =====
// ----------------------------------------------------------------------------
// byte_merge_sorter
// collects a string of bytes and returns it in ascending unsigned order
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o / in_item_i): one byte per item,
//   the item with last set closes the string. up to MAX_LEN bytes are kept,
//   later ones are dropped and every result of that string flags overflow.
//   output channel (out_valid_o / out_stall_i / out_item_o): one sorted byte
//   per item, end_of_run set on the final one.
// timing
//   fill takes one item per cycle. after the closing item the block stalls
//   input and runs ceil(log2(n)) merge passes, each after a setup state and
//   moving every byte once through the single write port of the stores,
//   then a setup state and one result per cycle while the receiver is free.
//   input opens again once the last result sits in the output register.
// reset
//   asynchronous, active low. clears counters, flags and the output valid.
//   store contents are not cleared; only bytes of the current string are read.
// stall
//   a stalled result holds in the output register and emission pauses.
// ----------------------------------------------------------------------------
module byte_merge_sorter #(
  parameter int MAX_LEN = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bmsort_pkg::in_item_t  in_item_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bmsort_pkg::out_item_t out_item_o
);

  // command and status between sequencer and datapath
  bmsort_pkg::cmd_t    cmd;
  bmsort_pkg::status_t stat;

  // sequencer: fill, merge passes, emission
  bmsort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // ping-pong stores, merge pointers, output register
  bmsort_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
